// ===== design/round_robin_thread_table_defines.svh =====
// Assertion macros for the round-robin thread table checker.
// No dependencies; expects clock and reset in the scope of use.
`ifndef ROUND_ROBIN_THREAD_TABLE_DEFINES_SVH
`define ROUND_ROBIN_THREAD_TABLE_DEFINES_SVH

// same-cycle implication
`define RRTT_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rrtt: same-cycle check failed");

// next-cycle implication
`define RRTT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rrtt: next-cycle check failed");

`endif

// ===== design/rrtt_pkg.sv =====
// Shared types and codes for the round-robin thread table.
// No dependencies.
package rrtt_pkg;

   localparam int THREAD_COUNT_DEF = 128;
   localparam int STATE_W          = 3;
   localparam int SLOT_FIELD_W     = 7;
   localparam int VALUE_W          = 64;

   typedef logic [STATE_W-1:0] thread_state_type;
   localparam thread_state_type ST_READY   = 3'd0;
   localparam thread_state_type ST_RUNNING = 3'd1;
   localparam thread_state_type ST_EXIT    = 3'd2;
   localparam thread_state_type ST_EMPTY   = 3'd3;
   localparam thread_state_type ST_BLOCKED = 3'd4;

   typedef logic [1:0] op_type;
   localparam op_type OP_TICK   = 2'd0;
   localparam op_type OP_CREATE = 2'd1;
   localparam op_type OP_JOIN   = 2'd2;
   localparam op_type OP_EXIT   = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type RSP_OK         = 2'd0;
   localparam status_type RSP_NO_SLOT    = 2'd1;
   localparam status_type RSP_BAD_TARGET = 2'd2;
   localparam status_type RSP_JOINED     = 2'd3;

   typedef struct packed {
      op_type                  op;
      logic [SLOT_FIELD_W-1:0] target_thread;
      logic [VALUE_W-1:0]      exit_value;
   } req_payload_type;

   typedef struct packed {
      status_type              status;
      logic [SLOT_FIELD_W-1:0] new_thread;
      logic [SLOT_FIELD_W-1:0] running_thread;
      logic                    switched;
      logic                    caller_blocked;
      logic [VALUE_W-1:0]      joined_value;
   } rsp_payload_type;

   typedef struct packed {
      logic start;
      logic want_ready;
   } scan_ctl_type;

   typedef struct packed {
      logic hit;
      logic miss;
   } scan_status_type;

endpackage

// ===== design/rrtt_ram.sv =====
// Generic simple dual-port RAM, registered read.
// No dependencies.
module rrtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/rrtt_scan.sv =====
// Circular slot scanner: one table entry probed per cycle, pipelined
// against the RAM's registered read. Uses rrtt_pkg.
module rrtt_scan #(
   parameter int THREAD_COUNT = rrtt_pkg::THREAD_COUNT_DEF,
   localparam int SLOT_W = $clog2(THREAD_COUNT)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rrtt_pkg::scan_ctl_type     ctl,
   input  logic [SLOT_W-1:0]          first_slot,
   input  rrtt_pkg::thread_state_type entry_state,
   output logic [SLOT_W-1:0]          probe_slot,
   output logic [SLOT_W-1:0]          hit_slot,
   output rrtt_pkg::scan_status_type  result
);
   import rrtt_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(THREAD_COUNT - 1);

   logic              active_ff, active_in;
   logic              want_ready_ff, want_ready_in;
   logic [SLOT_W-1:0] probe_ff, probe_in;
   logic [SLOT_W-1:0] left_ff, left_in;
   logic              check_valid_ff, check_valid_in;
   logic [SLOT_W-1:0] check_slot_ff, check_slot_in;
   logic              match;

   assign match = check_valid_ff &&
                  (want_ready_ff ? (entry_state == ST_READY) : (entry_state == ST_EMPTY));
   assign result.hit  = active_ff && match;
   assign result.miss = active_ff && !match && (left_ff == '0);
   assign probe_slot  = probe_ff;
   assign hit_slot    = check_slot_ff;

   always_comb begin
      active_in      = active_ff;
      want_ready_in  = want_ready_ff;
      probe_in       = probe_ff;
      left_in        = left_ff;
      check_valid_in = check_valid_ff;
      check_slot_in  = check_slot_ff;
      if (ctl.start) begin
         active_in      = 1'b1;
         want_ready_in  = ctl.want_ready;
         probe_in       = first_slot;
         left_in        = LAST_SLOT;
         check_valid_in = 1'b0;
      end else if (active_ff) begin
         if (result.hit || result.miss) begin
            active_in      = 1'b0;
            check_valid_in = 1'b0;
         end else begin
            // left is non-zero here, otherwise miss would have fired
            check_valid_in = 1'b1;
            check_slot_in  = probe_ff;
            probe_in       = (probe_ff == LAST_SLOT) ? '0 : probe_ff + 1'b1;
            left_in        = left_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         check_valid_ff <= 1'b0;
      end else begin
         active_ff      <= active_in;
         check_valid_ff <= check_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ready_ff <= want_ready_in;
      probe_ff      <= probe_in;
      left_ff       <= left_in;
      check_slot_ff <= check_slot_in;
   end

endmodule

// ===== design/round_robin_thread_table.sv =====
// Round-robin thread table top: sequencer, two rrtt_ram tables, rrtt_scan; uses rrtt_pkg.
// Operations: a schedule scans the table, reading one entry a cycle, for the next ready thread;
// tick = one schedule; join answers at once, or blocks the caller and schedules; exit wakes
// a blocked waiter if there is one, then schedules; create scans for an empty slot, then
// schedules if it finds one. Throughput: one transaction at a time, req_ready rises with
// rsp_valid; a stalled response holds the sequencer. Reset: clears the table, req_ready low.
module round_robin_thread_table #(
   parameter int THREAD_COUNT = rrtt_pkg::THREAD_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rrtt_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rrtt_pkg::rsp_payload_type rsp_data
);
   import rrtt_pkg::*;

   localparam int SLOT_W  = $clog2(THREAD_COUNT);
   // table entry: {state, waiter valid, waiter slot}
   localparam int ENTRY_W = STATE_W + 1 + SLOT_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(THREAD_COUNT - 1);

   // sequencer states
   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_J_RD     = 4'd2;
   localparam logic [3:0] S_J_CHK    = 4'd3;
   localparam logic [3:0] S_J_CUR_RD = 4'd4;
   localparam logic [3:0] S_J_BLK    = 4'd5;
   localparam logic [3:0] S_X_RD     = 4'd6;
   localparam logic [3:0] S_X_CHK    = 4'd7;
   localparam logic [3:0] S_X_WRD    = 4'd8;
   localparam logic [3:0] S_X_WAKE   = 4'd9;
   localparam logic [3:0] S_X_FIN    = 4'd10;
   localparam logic [3:0] S_S_RD     = 4'd11;
   localparam logic [3:0] S_S_CUR    = 4'd12;
   localparam logic [3:0] S_SCAN     = 4'd13;
   localparam logic [3:0] S_S_DEMOTE = 4'd14;
   localparam logic [3:0] S_DONE     = 4'd15;

   function automatic logic [ENTRY_W-1:0] make_entry(thread_state_type st, logic wv,
                                                     logic [SLOT_W-1:0] w);
      return {st, wv, w};
   endfunction

   // control registers
   logic [3:0]        state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // transaction working registers
   req_payload_type         req_ff, req_in;
   status_type              res_status_ff, res_status_in;
   logic [SLOT_FIELD_W-1:0] res_new_ff, res_new_in;
   logic                    res_sw_ff, res_sw_in;
   logic                    res_blk_ff, res_blk_in;
   logic [VALUE_W-1:0]      res_joined_ff, res_joined_in;
   logic                    scan_create_ff, scan_create_in;
   logic [ENTRY_W-1:0]      cur_entry_ff, cur_entry_in;
   logic [SLOT_W-1:0]       cand_ff, cand_in;
   logic [SLOT_W-1:0]       waiter_ff, waiter_in;
   rsp_payload_type         rsp_ff, rsp_in;

   // table RAM
   logic               tbl_wr_en;
   logic [SLOT_W-1:0]  tbl_wr_addr;
   logic [ENTRY_W-1:0] tbl_wr_data;
   logic [SLOT_W-1:0]  tbl_rd_addr;
   logic [ENTRY_W-1:0] tbl_rd_data;
   thread_state_type   rd_state;
   logic               rd_wv;
   logic [SLOT_W-1:0]  rd_w;

   // exit value RAM
   logic               val_wr_en;
   logic [VALUE_W-1:0] val_rd_data;

   // scanner
   scan_ctl_type       scan_ctl;
   scan_status_type    scan_res;
   logic [SLOT_W-1:0]  scan_first;
   logic [SLOT_W-1:0]  scan_probe;
   logic [SLOT_W-1:0]  scan_hit;

   logic [SLOT_W-1:0]  target_slot;
   logic               target_bad;
   logic [SLOT_W-1:0]  cur_next;
   thread_state_type   cur_state;

   assign rd_state    = tbl_rd_data[ENTRY_W-1 -: STATE_W];
   assign rd_wv       = tbl_rd_data[SLOT_W];
   assign rd_w        = tbl_rd_data[SLOT_W-1:0];
   assign cur_state   = cur_entry_ff[ENTRY_W-1 -: STATE_W];
   assign target_slot = SLOT_W'(req_ff.target_thread);
   assign target_bad  = 32'(req_ff.target_thread) >= THREAD_COUNT;
   assign cur_next    = (cur_ff == LAST_SLOT) ? '0 : cur_ff + 1'b1;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   rrtt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (THREAD_COUNT)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // exit values; only read for a join on an exited target, always written first
   rrtt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (THREAD_COUNT)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (cur_ff),
      .wr_data (req_ff.exit_value),
      .rd_addr (target_slot),
      .rd_data (val_rd_data)
   );

   rrtt_scan #(
      .THREAD_COUNT (THREAD_COUNT)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .first_slot  (scan_first),
      .entry_state (rd_state),
      .probe_slot  (scan_probe),
      .hit_slot    (scan_hit),
      .result      (scan_res)
   );

   // table read address follows the state that consumes the data next cycle
   always_comb begin
      unique case (state_ff)
         S_J_RD:  tbl_rd_addr = target_slot;
         S_X_WRD: tbl_rd_addr = waiter_ff;
         S_SCAN:  tbl_rd_addr = scan_probe;
         default: tbl_rd_addr = cur_ff;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      cur_in         = cur_ff;
      req_in         = req_ff;
      res_status_in  = res_status_ff;
      res_new_in     = res_new_ff;
      res_sw_in      = res_sw_ff;
      res_blk_in     = res_blk_ff;
      res_joined_in  = res_joined_ff;
      scan_create_in = scan_create_ff;
      cur_entry_in   = cur_entry_ff;
      cand_in        = cand_ff;
      waiter_in      = waiter_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      tbl_wr_en      = 1'b0;
      tbl_wr_addr    = cur_ff;
      tbl_wr_data    = make_entry(ST_EMPTY, 1'b0, '0);
      val_wr_en      = 1'b0;
      scan_ctl       = '0;
      scan_first     = cur_next;

      unique case (state_ff)
         S_CLEAR: begin
            // slot 0 comes up running, the rest empty, no waiters
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = clr_ff;
            tbl_wr_data = (clr_ff == '0) ? make_entry(ST_RUNNING, 1'b0, '0)
                                         : make_entry(ST_EMPTY, 1'b0, '0);
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               res_status_in = RSP_OK;
               res_new_in    = '0;
               res_sw_in     = 1'b0;
               res_blk_in    = 1'b0;
               res_joined_in = '0;
               unique case (req_data.op)
                  OP_TICK: begin
                     state_in = S_S_RD;
                  end
                  OP_CREATE: begin
                     // lowest empty slot from 1 upward
                     scan_ctl.start      = 1'b1;
                     scan_ctl.want_ready = 1'b0;
                     scan_first          = SLOT_W'(1);
                     scan_create_in      = 1'b1;
                     state_in            = S_SCAN;
                  end
                  OP_JOIN: begin
                     state_in = S_J_RD;
                  end
                  OP_EXIT: begin
                     state_in = S_X_RD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_J_RD: begin
            if (target_bad) begin
               res_status_in = RSP_BAD_TARGET;
               state_in      = S_DONE;
            end else begin
               state_in = S_J_CHK;
            end
         end
         S_J_CHK: begin
            if (rd_state == ST_EMPTY) begin
               res_status_in = RSP_BAD_TARGET;
               state_in      = S_DONE;
            end else if (rd_wv) begin
               res_status_in = RSP_JOINED;
               state_in      = S_DONE;
            end else begin
               // record caller as the one waiter; an exited target answers at once
               tbl_wr_en   = 1'b1;
               tbl_wr_addr = target_slot;
               tbl_wr_data = make_entry(rd_state, 1'b1, cur_ff);
               if (rd_state != ST_EXIT) begin
                  state_in = S_J_CUR_RD;
               end else begin
                  res_joined_in = val_rd_data;
                  state_in      = S_DONE;
               end
            end
         end
         S_J_CUR_RD: begin
            // fresh read so a self join keeps its own waiter mark
            state_in = S_J_BLK;
         end
         S_J_BLK: begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = cur_ff;
            tbl_wr_data = make_entry(ST_BLOCKED, rd_wv, rd_w);
            res_blk_in  = 1'b1;
            state_in    = S_S_RD;
         end
         S_X_RD: begin
            val_wr_en = 1'b1;
            state_in  = S_X_CHK;
         end
         S_X_CHK: begin
            if (rd_wv) begin
               waiter_in = rd_w;
               state_in  = S_X_WRD;
            end else begin
               state_in = S_X_FIN;
            end
         end
         S_X_WRD: begin
            state_in = S_X_WAKE;
         end
         S_X_WAKE: begin
            if (rd_state == ST_BLOCKED) begin
               tbl_wr_en   = 1'b1;
               tbl_wr_addr = waiter_ff;
               tbl_wr_data = make_entry(ST_READY, rd_wv, rd_w);
            end
            state_in = S_X_FIN;
         end
         S_X_FIN: begin
            // exited, waiter cleared; overrides a self-wake
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = cur_ff;
            tbl_wr_data = make_entry(ST_EXIT, 1'b0, '0);
            state_in    = S_S_RD;
         end
         S_S_RD: begin
            state_in = S_S_CUR;
         end
         S_S_CUR: begin
            cur_entry_in        = tbl_rd_data;
            scan_ctl.start      = 1'b1;
            scan_ctl.want_ready = 1'b1;
            scan_first          = cur_next;
            scan_create_in      = 1'b0;
            state_in            = S_SCAN;
         end
         S_SCAN: begin
            if (scan_res.hit) begin
               tbl_wr_en   = 1'b1;
               tbl_wr_addr = scan_hit;
               if (scan_create_ff) begin
                  tbl_wr_data = make_entry(ST_READY, 1'b0, '0);
                  res_new_in  = SLOT_FIELD_W'(scan_hit);
                  state_in    = S_S_RD;
               end else begin
                  tbl_wr_data = make_entry(ST_RUNNING, rd_wv, rd_w);
                  cand_in     = scan_hit;
                  state_in    = S_S_DEMOTE;
               end
            end else if (scan_res.miss) begin
               if (scan_create_ff) begin
                  res_status_in = RSP_NO_SLOT;
               end else if (cur_state == ST_READY) begin
                  // nobody else ready: current keeps the processor
                  tbl_wr_en   = 1'b1;
                  tbl_wr_addr = cur_ff;
                  tbl_wr_data = make_entry(ST_RUNNING, cur_entry_ff[SLOT_W],
                                           cur_entry_ff[SLOT_W-1:0]);
               end
               state_in = S_DONE;
            end
         end
         S_S_DEMOTE: begin
            if (cur_state == ST_RUNNING) begin
               tbl_wr_en   = 1'b1;
               tbl_wr_addr = cur_ff;
               tbl_wr_data = make_entry(ST_READY, cur_entry_ff[SLOT_W],
                                        cur_entry_ff[SLOT_W-1:0]);
            end
            cur_in    = cand_ff;
            res_sw_in = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status         = res_status_ff;
               rsp_in.new_thread     = res_new_ff;
               rsp_in.running_thread = SLOT_FIELD_W'(cur_ff);
               rsp_in.switched       = res_sw_ff;
               rsp_in.caller_blocked = res_blk_ff;
               rsp_in.joined_value   = res_joined_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      res_status_ff  <= res_status_in;
      res_new_ff     <= res_new_in;
      res_sw_ff      <= res_sw_in;
      res_blk_ff     <= res_blk_in;
      res_joined_ff  <= res_joined_in;
      scan_create_ff <= scan_create_in;
      cur_entry_ff   <= cur_entry_in;
      cand_ff        <= cand_in;
      waiter_ff      <= waiter_in;
      rsp_ff         <= rsp_in;
   end

endmodule

// ===== design/rrtt_checker.sv =====
// Port-level checks for the round-robin thread table, bound to the top level.
// Uses rrtt_pkg and round_robin_thread_table_defines.svh.
`include "round_robin_thread_table_defines.svh"

module rrtt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input rrtt_pkg::rsp_payload_type rsp_data
);
   import rrtt_pkg::*;

   logic rsp_refused;
   logic rsp_quiet;
   logic rsp_joined_now;
   logic rsp_no_move;

   assign rsp_refused    = rsp_valid && (rsp_data.status != RSP_OK);
   assign rsp_quiet      = !rsp_data.switched && !rsp_data.caller_blocked &&
                           (rsp_data.new_thread == '0);
   assign rsp_joined_now = rsp_valid && (rsp_data.joined_value != '0);
   assign rsp_no_move    = !rsp_data.switched && !rsp_data.caller_blocked;

   // one transaction in flight: busy straight after an accept
   `RRTT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // stalled result holds
   `RRTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // a refused operation changes nothing
   `RRTT_ASSERT_IMPLY(a_refused_quiet, rsp_refused, rsp_quiet)
   // an immediate join neither blocks nor reschedules
   `RRTT_ASSERT_IMPLY(a_joined_no_switch, rsp_joined_now, rsp_no_move)

endmodule

bind round_robin_thread_table rrtt_checker u_rrtt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
